/* rtl/gyi_pkg.sv */
// Package for the gyro yaw integrator: field widths, defaults and divider constants.
// No dependencies; used by gyro_yaw_integrator.
`default_nettype none

package gyi_pkg;

	localparam int DEF_CALIB_SAMPLES = 10;
	localparam int DEF_YAW_WIDTH     = 48;

	localparam int RAW_W      = 16;
	localparam int DEADBAND_W = 16;
	localparam int RATE_W     = 17;
	localparam int YAW_OUT_W  = 48;
	localparam int SUM_W      = 24;
	localparam int BIAS_W     = 16;

	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd13;

	// Reciprocal division of the calibration sum: exact for |sum| < 2**22 and up to 64 samples.
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam int M_TDATA_W = 72;

endpackage

`default_nettype wire

/* rtl/gyro_yaw_integrator.sv */
// Gyro Z bias calibration and saturating yaw integration, top level.
// Depends on gyi_pkg for widths, defaults and the reciprocal divider constants.
// Results pass through the input register and then the result register.
// Throughput is one transfer per cycle while m_tready is high, except for an input pause after the
// last calibration sample while the reciprocal multiplier forms the bias offset.
// Reset clears calibration, bias and yaw state and sets the deadband to 13 counts.
`default_nettype none

module gyro_yaw_integrator #(
	parameter int CALIB_SAMPLES = gyi_pkg::DEF_CALIB_SAMPLES,
	parameter int YAW_WIDTH     = gyi_pkg::DEF_YAW_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [gyi_pkg::DEADBAND_W-1:0]   cfg_wr_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// Fields from bit 0: gyro_z_raw[15:0].
	input  wire logic [gyi_pkg::RAW_W-1:0]        s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// Fields from bit 0: rate_counts[16:0], integrated[17], yaw_accum[65:18], zero fill.
	output logic [gyi_pkg::M_TDATA_W-1:0]         m_tdata,
	// Fields from bit 0: calibrating[0].
	output logic                                  m_tuser
);
	import gyi_pkg::*;

	localparam int CNT_W = $clog2(CALIB_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CALIB_SAMPLES - 1);
	localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(CALIB_SAMPLES);
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));
	localparam logic signed [YAW_WIDTH-1:0] YAW_MAX = {1'b0, {(YAW_WIDTH-1){1'b1}}};
	localparam logic signed [YAW_WIDTH-1:0] YAW_MIN = {1'b1, {(YAW_WIDTH-1){1'b0}}};

	logic [DEADBAND_W-1:0] deadband_q;
	logic [CNT_W-1:0] calib_cnt_q;
	logic signed [SUM_W-1:0] calib_sum_q;
	logic signed [BIAS_W-1:0] bias_q;
	logic signed [YAW_WIDTH-1:0] yaw_q;

	logic div_go_q;
	logic prod_vld_q;
	logic [PROD_W-1:0] prod_q;
	logic prod_neg_q;

	logic v_s1;
	logic signed [RAW_W-1:0] raw_s1;
	logic v_s2;

	logic div_pend;
	logic adv;
	logic calib_phase;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0] sum_mag;
	logic [RATE_W:0] quot;
	logic signed [RATE_W-1:0] diff;
	logic [RATE_W-1:0] mag;
	logic add;
	logic signed [YAW_WIDTH:0] yaw_sum;
	logic signed [YAW_WIDTH-1:0] yaw_sat;
	logic signed [YAW_WIDTH-1:0] yaw_next;
	logic signed [63:0] yaw_wide;
	logic [M_TDATA_W-1:0] tdata_next;

	assign div_pend    = div_go_q | prod_vld_q;
	assign adv         = v_s1 && !div_pend && (!v_s2 || m_tready);
	assign s_tready    = !v_s1 || adv;
	assign m_tvalid    = v_s2;
	assign calib_phase = calib_cnt_q != CNT_DONE;

	always_comb begin
		sum_next = calib_sum_q + SUM_W'(raw_s1);
		diff     = RATE_W'(raw_s1) - RATE_W'(bias_q);
		mag      = diff[RATE_W-1] ? RATE_W'(-diff) : RATE_W'(diff);
		add      = mag > RATE_W'(deadband_q);
		yaw_sum  = (YAW_WIDTH+1)'(yaw_q) + (YAW_WIDTH+1)'(diff);
		if (yaw_sum[YAW_WIDTH] != yaw_sum[YAW_WIDTH-1]) begin
			yaw_sat = yaw_sum[YAW_WIDTH] ? YAW_MIN : YAW_MAX;
		end else begin
			yaw_sat = yaw_sum[YAW_WIDTH-1:0];
		end
		if (!calib_phase && add) begin
			yaw_next = yaw_sat;
		end else begin
			yaw_next = yaw_q;
		end
		yaw_wide = 64'(yaw_next);
		tdata_next = '0;
		if (!calib_phase) begin
			tdata_next[RATE_W-1:0] = diff;
			tdata_next[RATE_W]     = add;
		end
		tdata_next[RATE_W+1 +: YAW_OUT_W] = yaw_wide[YAW_OUT_W-1:0];
	end

	assign sum_mag = calib_sum_q[SUM_W-1] ? SUM_W'(-calib_sum_q) : SUM_W'(calib_sum_q);
	assign quot    = prod_q[RECIP_SHIFT +: RATE_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q  <= DEADBAND_RESET;
			calib_cnt_q <= '0;
			calib_sum_q <= '0;
			bias_q      <= '0;
			yaw_q       <= '0;
			div_go_q    <= 1'b0;
			prod_vld_q  <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				deadband_q <= cfg_wr_data;
			end
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
			div_go_q   <= adv && calib_phase && (calib_cnt_q == CNT_LAST);
			prod_vld_q <= div_go_q;
			if (prod_vld_q) begin
				bias_q <= prod_neg_q ? BIAS_W'(-quot) : BIAS_W'(quot);
			end
			if (adv) begin
				if (calib_phase) begin
					calib_sum_q <= sum_next;
					calib_cnt_q <= calib_cnt_q + CNT_W'(1);
				end
				yaw_q <= yaw_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			raw_s1 <= s_tdata;
		end
		if (div_go_q) begin
			prod_q     <= PROD_W'(sum_mag) * PROD_W'(RECIP);
			prod_neg_q <= calib_sum_q[SUM_W-1];
		end
		if (adv) begin
			m_tuser <= calib_phase;
			m_tdata <= tdata_next;
		end
	end

	a_no_adv_while_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_pend |-> !adv)
		else $error("sample processed while the bias offset is being computed");

	a_bias_only_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		!prod_vld_q |=> $stable(bias_q))
		else $error("bias offset changed outside the divider write");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		calib_cnt_q <= CNT_DONE)
		else $error("calibration count ran past the sample count");

	a_calib_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[RATE_W:0] == '0)
		else $error("calibration result carries a rate or an integration flag");

	a_yaw_quiet_in_calib: assert property (@(posedge clk) disable iff (!arst_n)
		calib_phase |-> yaw_q == '0)
		else $error("yaw accumulator moved during calibration");

endmodule

`default_nettype wire

/* sim/gyro_yaw_integrator_test.sv */
// Self-checking testbench for gyro_yaw_integrator: bias calibration, deadband and yaw sums.
// Depends on gyi_pkg and the gyro_yaw_integrator RTL; an internal predictor checks every
// untyped result under random stalls on both streams and several deadband settings.

module gyro_yaw_integrator_test;

	localparam int       CAL_COUNT   = gyi_pkg::DEF_CALIB_SAMPLES;
	localparam longint   YAW_MAX     = (longint'(1) <<< (gyi_pkg::DEF_YAW_WIDTH - 1)) - 1;
	localparam longint   YAW_MIN     = -YAW_MAX - 1;
	localparam int       ITEMS_PER_SETTING = 400;
	localparam int       LONG_HOLD   = 300;
	localparam int       N_DIRECTED  = 21;
	localparam int       N_SETTINGS  = 5;

	typedef struct packed {
		logic               calibrating;
		logic signed [16:0] rate;
		logic               integrated;
		logic signed [47:0] yaw;
	} yaw_result_t;

	typedef struct packed {
		logic [15:0] raw;
		logic        typed;
		yaw_result_t want;
	} stim_row_t;

	localparam yaw_result_t CAL_RESULT = {1'b1, 17'd0, 1'b0, 48'd0};
	localparam yaw_result_t NO_RESULT  = '0;

	// Calibration rows sum to -211, so the bias truncates toward zero to -21.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{16'h7FFF, 1'b1, CAL_RESULT}, '{16'h8000, 1'b1, CAL_RESULT},
		'{16'h0001, 1'b1, CAL_RESULT}, '{16'hFFFF, 1'b1, CAL_RESULT},
		'{16'h0000, 1'b1, CAL_RESULT}, '{16'hFF38, 1'b1, CAL_RESULT},
		'{16'hFFF9, 1'b1, CAL_RESULT}, '{16'h3039, 1'b1, CAL_RESULT},
		'{16'hCFC7, 1'b1, CAL_RESULT}, '{16'hFFFD, 1'b1, CAL_RESULT},
		'{16'hFFEB, 1'b0, NO_RESULT},  '{16'hFFF8, 1'b0, NO_RESULT},
		'{16'hFFF9, 1'b0, NO_RESULT},  '{16'hFFDE, 1'b0, NO_RESULT},
		'{16'hFFDD, 1'b0, NO_RESULT},  '{16'h7FFF, 1'b0, NO_RESULT},
		'{16'h8000, 1'b0, NO_RESULT},  '{16'h0000, 1'b0, NO_RESULT},
		'{16'hFFFF, 1'b0, NO_RESULT},  '{16'h5555, 1'b0, NO_RESULT},
		'{16'hAAAA, 1'b0, NO_RESULT}
	};

	logic                                clk         = 1'b0;
	logic                                arst_n      = 1'b0;
	logic                                cfg_wr_en   = 1'b0;
	logic [gyi_pkg::DEADBAND_W-1:0]      cfg_wr_data = '0;
	logic                                s_tvalid    = 1'b0;
	logic                                s_tready;
	logic [gyi_pkg::RAW_W-1:0]           s_tdata     = '0;
	logic                                m_tvalid;
	logic                                m_tready    = 1'b0;
	logic [gyi_pkg::M_TDATA_W-1:0]       m_tdata;
	logic                                m_tuser;

	// Predictor state.
	int                                  cal_taken  = 0;
	int                                  cal_acc    = 0;
	logic signed [15:0]                  bias       = '0;
	longint                              yaw_sum    = 0;
	logic [15:0]                         deadband   = gyi_pkg::DEADBAND_RESET;

	yaw_result_t                         awaited_results [$];
	int                                  mismatches       = 0;
	int                                  results_checked  = 0;
	int                                  calib_seen       = 0;
	int                                  integrated_seen  = 0;
	int                                  settings_used    = 0;
	int                                  quiet_left       = 0;
	bit                                  sink_hold_req    = 1'b0;

	gyro_yaw_integrator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic yaw_result_t integrate_sample(input logic signed [15:0] raw);
		yaw_result_t        r;
		logic signed [16:0] diff;
		logic [16:0]        mag;
		r = '0;
		if (cal_taken < CAL_COUNT) begin
			cal_acc += int'(raw);
			cal_taken++;
			if (cal_taken == CAL_COUNT)
				bias = 16'(cal_acc / CAL_COUNT);
			r.calibrating = 1'b1;
			r.yaw = yaw_sum[47:0];
			return r;
		end
		diff = raw - bias;
		mag = (diff < 0) ? -diff : diff;
		r.integrated = mag > {1'b0, deadband};
		if (r.integrated) begin
			yaw_sum = yaw_sum + longint'(diff);
			if (yaw_sum > YAW_MAX)
				yaw_sum = YAW_MAX;
			else if (yaw_sum < YAW_MIN)
				yaw_sum = YAW_MIN;
		end
		r.rate = diff;
		r.yaw = yaw_sum[47:0];
		return r;
	endfunction

	function automatic logic [15:0] random_raw();
		int v;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			v = int'(deadband) + int'($urandom_range(0, 4)) - 2;
			v = int'(bias) + ($urandom_range(0, 1) ? v : -v);
		end else if (kind < 7) begin
			return 16'($urandom);
		end else if (kind == 7) begin
			case ($urandom_range(0, 3))
				0: return 16'h7FFF;
				1: return 16'h8000;
				2: return 16'h0000;
				default: return 16'hFFFF;
			endcase
		end else begin
			v = int'(bias) + int'($urandom_range(0, 200)) - 100;
		end
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 50) begin
			quiet_left = $urandom_range(30, 80);
			return 0;
		end
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic offer_sample(input logic [15:0] raw, input logic typed,
			input yaw_result_t want);
		yaw_result_t predicted;
		int          gap;
		s_tvalid <= 1'b1;
		s_tdata <= raw;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = integrate_sample(raw);
		awaited_results.push_back(typed ? want : predicted);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_deadband(input logic [15:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		deadband = value;
		settings_used++;
	endtask

	initial begin
		int mode;
		@(posedge clk);
		forever begin
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 9);
				if (mode < 3) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(20, 60)) @(posedge clk);
				end else if (mode < 8) begin
					m_tready <= ($urandom_range(0, 9) < 7);
					@(posedge clk);
				end else if (mode < 9) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		yaw_result_t want;
		if (m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				$error("Result transfer arrived with no result outstanding.");
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				results_checked++;
				if (m_tuser !== want.calibrating) begin
					$error("calibrating: expected %0d, got %0d", want.calibrating, m_tuser);
					mismatches++;
				end
				if (m_tdata[16:0] !== want.rate) begin
					$error("rate_counts: expected %0d, got %0d", want.rate,
						$signed(m_tdata[16:0]));
					mismatches++;
				end
				if (m_tdata[17] !== want.integrated) begin
					$error("integrated: expected %0d, got %0d", want.integrated, m_tdata[17]);
					mismatches++;
				end
				if (m_tdata[65:18] !== want.yaw) begin
					$error("yaw_accum: expected %0d, got %0d", want.yaw,
						$signed(m_tdata[65:18]));
					mismatches++;
				end
				if (want.calibrating)
					calib_seen++;
				if (want.integrated)
					integrated_seen++;
			end
		end
	end

	initial begin
		#20000000;
		$display("Timeout with %0d results still outstanding.", awaited_results.size());
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		logic [15:0] settings [N_SETTINGS];
		settings[0] = 16'd0;
		settings[1] = 16'hFFFF;
		settings[2] = gyi_pkg::DEADBAND_RESET;
		settings[3] = 16'($urandom_range(1, 200));
		settings[4] = 16'($urandom_range(1000, 40000));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			offer_sample(DIRECTED[i].raw, DIRECTED[i].typed, DIRECTED[i].want);
		drain_results();
		for (int p = 0; p < N_SETTINGS; p++) begin
			write_deadband(settings[p]);
			if (p == 1)
				sink_hold_req = 1'b1;
			for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
				offer_sample(random_raw(), 1'b0, NO_RESULT);
				if (p == 3 && i == ITEMS_PER_SETTING / 2)
					drain_results();
			end
			drain_results();
		end
		repeat (10) @(posedge clk);
		$display("Checked %0d results: %0d during calibration, %0d integrated.",
			results_checked, calib_seen, integrated_seen);
		$display("Deadband settings used: %0d, including 0 and 65535; final yaw %0d.",
			settings_used, yaw_sum);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* sim.f */
rtl/gyi_pkg.sv
rtl/gyro_yaw_integrator.sv
sim/gyro_yaw_integrator_test.sv
